FILE: rtl/core/rie_pkg.sv
// shared types and constants for the risc instruction execute unit
// no dependencies; used by every file in rtl/core
package rie_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam logic ITEM_PRELOAD = 1'b1;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_SLT  = 4'd2,
    OP_OR   = 4'd3,
    OP_NAND = 4'd4,
    OP_ADDI = 4'd5,
    OP_SLTI = 4'd6,
    OP_ORI  = 4'd7,
    OP_LUI  = 4'd8,
    OP_LW   = 4'd9,
    OP_SW   = 4'd10,
    OP_BEQ  = 4'd11,
    OP_JALR = 4'd12,
    OP_J    = 4'd13,
    OP_HALT = 4'd14,
    OP_ILL  = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC,
    B_LOAD
  } back_state_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] instruction_word;
    logic [6:0]  preload_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic               halted;
    logic               reg_write;
    logic [3:0]         write_index;
    logic signed [31:0] write_value;
    logic               mem_error;
    logic               illegal;
    logic [15:0]        used_mask;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        preload;
    op_t         op;
    logic [3:0]  rs;
    logic [3:0]  rt;
    logic [3:0]  rd;
    logic [15:0] imm;
    logic [31:0] simm;
    logic [31:0] word;
    logic [6:0]  pa;
  } decoded_t;

endpackage

FILE: rtl/core/rie_queue.sv
// small first-in first-out queue of packed words
// depends on rie_pkg for its depth
module rie_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (rie_pkg::QUEUE_DEPTH > 1) ? $clog2(rie_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(rie_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(rie_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(rie_pkg::QUEUE_DEPTH);

  logic [WIDTH-1:0] mem [rie_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/rie_front.sv
// front end: takes input items, splits out the instruction fields and
// queues them for the back end; depends on rie_pkg and rie_queue
module rie_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rie_pkg::in_item_t  instr,
  output logic               full,
  input  logic               clearing,
  input  logic               dec_pop,
  output rie_pkg::decoded_t  dec,
  output logic               dec_empty
);

  rie_pkg::decoded_t cls;
  logic              q_full;
  logic              q_push;
  logic [$bits(rie_pkg::decoded_t)-1:0] q_out;

  always_comb begin
    cls.preload = (instr.opcode == rie_pkg::ITEM_PRELOAD);
    cls.op      = rie_pkg::op_t'(instr.instruction_word[27:24]);
    cls.rs      = instr.instruction_word[23:20];
    cls.rt      = instr.instruction_word[19:16];
    cls.rd      = instr.instruction_word[15:12];
    cls.imm     = instr.instruction_word[15:0];
    cls.simm    = {{16{instr.instruction_word[15]}}, instr.instruction_word[15:0]};
    cls.word    = instr.instruction_word;
    cls.pa      = instr.preload_address;
  end

  // hold off the source while data memory is still being cleared
  assign full   = q_full || clearing;
  assign q_push = push && !full;

  rie_queue #(
    .WIDTH($bits(rie_pkg::decoded_t))
  ) u_dec_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (cls),
    .full  (q_full),
    .pop   (dec_pop),
    .dout  (q_out),
    .empty (dec_empty)
  );

  assign dec = rie_pkg::decoded_t'(q_out);

endmodule

FILE: rtl/core/rie_back.sv
// back end: register file, data memory, pc and flags; runs one request
// at a time and pushes its result; depends on rie_pkg
module rie_back #(
  parameter int DATA_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  rie_pkg::decoded_t   dec,
  input  logic                dec_empty,
  output logic                dec_pop,
  output logic                clearing,
  output rie_pkg::out_item_t  res,
  output logic                out_push,
  input  logic                out_full
);

  localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DATA_DEPTH - 1);
  localparam logic [31:0]   DEPTH32   = 32'(DATA_DEPTH);

  function automatic logic [15:0] onehot(input logic [3:0] idx);
    logic [15:0] v;
    v = '0;
    v[idx] = 1'b1;
    return v;
  endfunction

  rie_pkg::back_state_t state;
  rie_pkg::back_state_t state_next;
  rie_pkg::decoded_t    item;

  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] clr_cnt_next;
  logic [15:0]   pc;
  logic [15:0]   pc_next;
  logic          halt_flag;
  logic          halt_flag_next;
  logic [15:0]   used;
  logic [15:0]   used_next;
  logic [15:0]   rf_valid;

  logic [31:0] rf [16];
  logic [31:0] rf_a;
  logic [31:0] rf_b;
  logic        va;
  logic        vb;
  logic        rf_we;
  logic [3:0]  rf_widx;
  logic [31:0] rf_wdata;

  logic [31:0]   dmem [DATA_DEPTH];
  logic [31:0]   mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] addend;
  logic [31:0] sum;
  logic        lt_ab;
  logic        lt_ai;
  logic        addr_ok;
  logic        pre_ok;
  logic [15:0] npc_inc;
  logic [15:0] marks_st;

  assign clearing = (state == rie_pkg::B_CLEAR);

  // operands: an entry never written reads as zero
  assign a = va ? rf_a : '0;
  assign b = vb ? rf_b : '0;

  always_comb begin
    priority case (item.op)
      rie_pkg::OP_ADD: addend = b;
      rie_pkg::OP_SUB: addend = ~b;
      default:         addend = item.simm;
    endcase
  end

  assign sum      = a + addend + {31'b0, (item.op == rie_pkg::OP_SUB)};
  assign lt_ab    = ($signed(a) < $signed(b));
  assign lt_ai    = ($signed(a) < $signed(item.simm));
  assign addr_ok  = (sum < DEPTH32);
  assign pre_ok   = (32'(item.pa) < DEPTH32);
  assign npc_inc  = pc + 16'd1;
  assign marks_st = used | onehot(item.rs) | onehot(item.rt);

  always_comb begin
    logic        wr;
    logic [3:0]  widx;
    logic [31:0] wval;
    logic [15:0] npc;
    logic        merr;
    logic        ill;
    logic        hlt;
    logic [15:0] un;

    state_next     = state;
    clr_cnt_next   = clr_cnt;
    dec_pop        = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = clr_cnt;
    mem_wdata      = '0;
    rf_we          = 1'b0;
    rf_widx        = item.rt;
    rf_wdata       = '0;
    pc_next        = pc;
    halt_flag_next = halt_flag;
    used_next      = used;
    out_push       = 1'b0;
    res            = '0;
    res.next_pc    = pc;
    res.halted     = halt_flag;
    res.used_mask  = used;

    wr   = 1'b0;
    widx = '0;
    wval = '0;
    npc  = npc_inc;
    merr = 1'b0;
    ill  = 1'b0;
    hlt  = halt_flag;
    un   = used;

    unique case (state)
      rie_pkg::B_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt == LAST_ADDR) begin
          state_next = rie_pkg::B_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + 1'b1;
        end
      end

      rie_pkg::B_IDLE: begin
        if (!dec_empty && !out_full) begin
          dec_pop    = 1'b1;
          state_next = rie_pkg::B_EXEC;
        end
      end

      rie_pkg::B_EXEC: begin
        state_next = rie_pkg::B_IDLE;
        if (item.preload) begin
          if (pre_ok) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(item.pa);
            mem_wdata = item.word;
          end
          res.mem_error = !pre_ok;
          out_push      = 1'b1;
        end else if (halt_flag) begin
          out_push = 1'b1;
        end else begin
          unique case (item.op)
            rie_pkg::OP_ADD, rie_pkg::OP_SUB: begin
              wr = 1'b1; widx = item.rd; wval = sum;
              un = marks_st | onehot(item.rd);
            end
            rie_pkg::OP_SLT: begin
              wr = 1'b1; widx = item.rd; wval = {31'b0, lt_ab};
              un = marks_st | onehot(item.rd);
            end
            rie_pkg::OP_OR: begin
              wr = 1'b1; widx = item.rd; wval = a | b;
              un = marks_st | onehot(item.rd);
            end
            rie_pkg::OP_NAND: begin
              wr = 1'b1; widx = item.rd; wval = ~(a & b);
              un = marks_st | onehot(item.rd);
            end
            rie_pkg::OP_ADDI: begin
              wr = 1'b1; widx = item.rt; wval = sum; un = marks_st;
            end
            rie_pkg::OP_SLTI: begin
              wr = 1'b1; widx = item.rt; wval = {31'b0, lt_ai}; un = marks_st;
            end
            rie_pkg::OP_ORI: begin
              wr = 1'b1; widx = item.rt; wval = a | {16'b0, item.imm}; un = marks_st;
            end
            rie_pkg::OP_LUI: begin
              wr = 1'b1; widx = item.rt; wval = {item.imm, 16'b0};
              un = used | onehot(item.rt);
            end
            rie_pkg::OP_LW: begin
              // in range: finish once the memory word is back
              if (addr_ok) begin
                state_next = rie_pkg::B_LOAD;
              end else begin
                merr = 1'b1;
              end
              un = marks_st;
            end
            rie_pkg::OP_SW: begin
              if (addr_ok) begin
                mem_we    = 1'b1;
                mem_waddr = sum[AW-1:0];
                mem_wdata = b;
              end else begin
                merr = 1'b1;
              end
              un = marks_st;
            end
            rie_pkg::OP_BEQ: begin
              if (a == b) begin
                npc = 16'(pc + item.imm + 16'd1);
              end
              un = marks_st;
            end
            rie_pkg::OP_JALR: begin
              wr = 1'b1; widx = item.rt; wval = {16'b0, npc_inc};
              // link is written first, so rs equal to rt sees the link value
              npc = (item.rs == item.rt) ? npc_inc : a[15:0];
              un = marks_st;
            end
            rie_pkg::OP_J: begin
              npc = item.imm;
            end
            rie_pkg::OP_HALT: begin
              hlt = 1'b1;
            end
            rie_pkg::OP_ILL: begin
              ill = 1'b1;
              npc = pc;
            end
          endcase

          if (state_next != rie_pkg::B_LOAD) begin
            rf_we           = wr;
            rf_widx         = widx;
            rf_wdata        = wval;
            pc_next         = npc;
            halt_flag_next  = hlt;
            used_next       = un;
            out_push        = 1'b1;
            res.next_pc     = npc;
            res.halted      = hlt;
            res.reg_write   = wr;
            res.write_index = widx;
            res.write_value = $signed(wval);
            res.mem_error   = merr;
            res.illegal     = ill;
            res.used_mask   = un;
          end
        end
      end

      rie_pkg::B_LOAD: begin
        state_next      = rie_pkg::B_IDLE;
        rf_we           = 1'b1;
        rf_widx         = item.rt;
        rf_wdata        = mem_rdata;
        pc_next         = npc_inc;
        used_next       = marks_st;
        out_push        = 1'b1;
        res.next_pc     = npc_inc;
        res.reg_write   = 1'b1;
        res.write_index = item.rt;
        res.write_value = $signed(mem_rdata);
        res.used_mask   = marks_st;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dec_pop) begin
      item <= dec;
    end
  end

  // register file, read at the queue head while idle
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_widx] <= rf_wdata;
    end
    rf_a <= rf[dec.rs];
    rf_b <= rf[dec.rt];
    va   <= rf_valid[dec.rs];
    vb   <= rf_valid[dec.rt];
  end

  // data memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= dmem[sum[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rie_pkg::B_CLEAR;
      clr_cnt   <= '0;
      pc        <= '0;
      halt_flag <= 1'b0;
      used      <= '0;
      rf_valid  <= '0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      pc        <= pc_next;
      halt_flag <= halt_flag_next;
      used      <= used_next;
      if (rf_we) begin
        rf_valid[rf_widx] <= 1'b1;
      end
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result pushed into a full queue");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == rie_pkg::B_CLEAR) |-> !dec_pop)
    else $error("request taken during memory clear");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_flag |=> halt_flag)
    else $error("halt flag dropped");

  a_load_done: assert property (@(posedge clk) disable iff (rst)
    (state == rie_pkg::B_LOAD) |=> (state == rie_pkg::B_IDLE))
    else $error("load did not complete");

  a_rf_write_state: assert property (@(posedge clk) disable iff (rst)
    rf_we |-> ((state == rie_pkg::B_EXEC) || (state == rie_pkg::B_LOAD)))
    else $error("register write outside execute");

endmodule

FILE: rtl/core/risc_instruction_execute_unit.sv
// top level: front end, back end and result queue of the execute unit
// depends on rie_pkg, rie_queue, rie_front and rie_back
// an accepted item waits in the front queue; the back end pops it in idle,
// reads its registers and pushes the result in execute, or in the load state
// after the memory read for an in-range lw; no new item is taken until idle
// again, nor while the result queue is full; reset: rst sweeps data memory
// to zero with full high; registers, pc, halt flag, used mask zero at once
module risc_instruction_execute_unit #(
  parameter int DATA_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rie_pkg::in_item_t  instr,
  output logic               full,
  input  logic               pop,
  output rie_pkg::out_item_t result,
  output logic               empty
);

  rie_pkg::decoded_t  dec;
  rie_pkg::out_item_t res;
  logic               dec_empty;
  logic               dec_pop;
  logic               clearing;
  logic               out_push;
  logic               out_full;
  logic [$bits(rie_pkg::out_item_t)-1:0] out_word;

  rie_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .instr     (instr),
    .full      (full),
    .clearing  (clearing),
    .dec_pop   (dec_pop),
    .dec       (dec),
    .dec_empty (dec_empty)
  );

  rie_back #(
    .DATA_DEPTH(DATA_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .dec       (dec),
    .dec_empty (dec_empty),
    .dec_pop   (dec_pop),
    .clearing  (clearing),
    .res       (res),
    .out_push  (out_push),
    .out_full  (out_full)
  );

  rie_queue #(
    .WIDTH($bits(rie_pkg::out_item_t))
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (res),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_word),
    .empty (empty)
  );

  assign result = rie_pkg::out_item_t'(out_word);

endmodule
